FILE: hw/rtl/slbl_pkg.sv
// Shared types and constants for the serial boot stream loader.
package slbl_pkg;

  localparam logic [15:0] KEY_WORD       = 16'h08AA;
  localparam logic [15:0] ZERO_WORD      = 16'h0000;
  localparam logic [3:0]  RESERVED_WORDS = 4'd8;
  localparam logic [31:0] FALLBACK_RESET = 32'h0033_FFF6;

  localparam logic [1:0] ST_LOADING = 2'd0;
  localparam logic [1:0] ST_DONE    = 2'd1;
  localparam logic [1:0] ST_ABORT   = 2'd2;

  typedef enum logic [7:0] {
    PH_KEY     = 8'b0000_0001,
    PH_HEADER  = 8'b0000_0010,
    PH_SIZE    = 8'b0000_0100,
    PH_DEST_HI = 8'b0000_1000,
    PH_DEST_LO = 8'b0001_0000,
    PH_DATA    = 8'b0010_0000,
    PH_DONE    = 8'b0100_0000,
    PH_ABORT   = 8'b1000_0000
  } phase_t;

  typedef struct packed {
    phase_t      phase;
    logic [7:0]  low_byte_hold;
    logic        byte_half;
    logic [3:0]  word_count;
    logic [15:0] high_word_hold;
    logic [31:0] entry_store;
    logic [15:0] words_left;
    logic [31:0] dest_pointer;
  } ldr_state_t;

  typedef struct packed {
    logic        echo_valid;
    logic [7:0]  echo_byte;
    logic        write_valid;
    logic [31:0] write_addr;
    logic [15:0] write_data;
    logic [1:0]  status;
    logic [31:0] entry_addr;
  } ldr_result_t;

endpackage

FILE: hw/rtl/serial_boot_stream_loader_top.sv
// Top level of the serial boot stream loader: state, config and result registers.
// Takes one received byte per transfer and returns exactly one result per byte,
// in the cycle after the byte is taken. A new byte can be taken every cycle: the
// parser updates the loader state in one pass and the result lands in a single
// output register, so in_ready stays high while that register is empty or being
// drained in the same cycle. The fallback entry register is written through the
// cfg port at any time and is sampled only when the key word is checked.
module serial_boot_stream_loader_top import slbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_echo_valid,
  output logic [7:0]  out_echo_byte,
  output logic        out_write_valid,
  output logic [31:0] out_write_addr,
  output logic [15:0] out_write_data,
  output logic [1:0]  out_status,
  output logic [31:0] out_entry_addr,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  ldr_state_t  st_r, st_nxt;
  ldr_result_t res_r, res_nxt;
  logic        out_valid_r;
  logic [31:0] fallback_r;
  logic        in_fire;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  slbl_parse u_parse (
    .st             (st_r),
    .rx_byte        (in_rx_byte),
    .fallback_entry (fallback_r),
    .st_nxt         (st_nxt),
    .res            (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '{phase: PH_KEY, default: '0};
      out_valid_r <= 1'b0;
      fallback_r  <= FALLBACK_RESET;
    end else begin
      if (cfg_valid) begin
        fallback_r <= cfg_data;
      end
      if (in_fire) begin
        st_r        <= st_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_echo_valid  = res_r.echo_valid;
  assign out_echo_byte   = res_r.echo_byte;
  assign out_write_valid = res_r.write_valid;
  assign out_write_addr  = res_r.write_addr;
  assign out_write_data  = res_r.write_data;
  assign out_status      = res_r.status;
  assign out_entry_addr  = res_r.entry_addr;

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> out_valid)
    else $error("accepted byte produced no result");

  a_write_is_echoed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_valid |-> out_echo_valid && out_status == ST_LOADING)
    else $error("memory write without echo or after end of load");

  a_ignore_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && (st_r.phase == PH_DONE || st_r.phase == PH_ABORT)
      |=> !out_echo_valid && out_status != ST_LOADING)
    else $error("byte consumed after load finished");

  a_loading_entry_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_LOADING |-> out_entry_addr == 32'd0)
    else $error("entry address shown while loading");

endmodule

FILE: hw/rtl/slbl_parse.sv
// Per-byte parser: next loader state and result for one received byte.
module slbl_parse import slbl_pkg::*; (
  input  ldr_state_t  st,
  input  logic [7:0]  rx_byte,
  input  logic [31:0] fallback_entry,
  output ldr_state_t  st_nxt,
  output ldr_result_t res
);

  logic [15:0] word;
  logic [15:0] left_dec;

  assign word     = {rx_byte, st.low_byte_hold};
  assign left_dec = st.words_left - 16'd1;

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (st.phase != PH_DONE && st.phase != PH_ABORT) begin
      res.echo_valid = 1'b1;
      res.echo_byte  = rx_byte;
      if (!st.byte_half) begin
        st_nxt.low_byte_hold = rx_byte;
        st_nxt.byte_half     = 1'b1;
      end else begin
        st_nxt.byte_half = 1'b0;
        case (st.phase)
          PH_KEY: begin
            if (word == KEY_WORD) begin
              st_nxt.phase      = PH_HEADER;
              st_nxt.word_count = 4'd0;
            end else begin
              st_nxt.entry_store = fallback_entry;
              st_nxt.phase       = PH_ABORT;
            end
          end
          PH_HEADER: begin
            if (st.word_count < RESERVED_WORDS) begin
              st_nxt.word_count = st.word_count + 4'd1;
            end else if (st.word_count == RESERVED_WORDS) begin
              st_nxt.high_word_hold = word;
              st_nxt.word_count     = st.word_count + 4'd1;
            end else begin
              st_nxt.entry_store = {st.high_word_hold, word};
              st_nxt.phase       = PH_SIZE;
            end
          end
          PH_SIZE: begin
            if (word == ZERO_WORD) begin
              st_nxt.phase = PH_DONE;
            end else begin
              st_nxt.words_left = word;
              st_nxt.phase      = PH_DEST_HI;
            end
          end
          PH_DEST_HI: begin
            st_nxt.high_word_hold = word;
            st_nxt.phase          = PH_DEST_LO;
          end
          PH_DEST_LO: begin
            st_nxt.dest_pointer = {st.high_word_hold, word};
            st_nxt.phase        = PH_DATA;
          end
          default: begin
            res.write_valid     = 1'b1;
            res.write_addr      = st.dest_pointer;
            res.write_data      = word;
            st_nxt.dest_pointer = st.dest_pointer + 32'd1;
            st_nxt.words_left   = left_dec;
            if (left_dec == ZERO_WORD) begin
              st_nxt.phase = PH_SIZE;
            end
          end
        endcase
      end
    end
    if (st_nxt.phase == PH_DONE) begin
      res.status     = ST_DONE;
      res.entry_addr = st_nxt.entry_store;
    end else if (st_nxt.phase == PH_ABORT) begin
      res.status     = ST_ABORT;
      res.entry_addr = st_nxt.entry_store;
    end else begin
      res.status     = ST_LOADING;
      res.entry_addr = 32'd0;
    end
  end

endmodule

FILE: dv/serial_boot_stream_loader_checker.sv
// Checker for the serial boot stream loader: predicts each result and compares it.
module serial_boot_stream_loader_checker import slbl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  in_rx_byte,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_echo_valid,
  input  logic [7:0]  out_echo_byte,
  input  logic        out_write_valid,
  input  logic [31:0] out_write_addr,
  input  logic [15:0] out_write_data,
  input  logic [1:0]  out_status,
  input  logic [31:0] out_entry_addr,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          pending
);

  phase_t      phase;
  logic [7:0]  low_hold;
  logic        hi_next;
  logic [3:0]  hdr_idx;
  logic [15:0] hi_hold;
  logic [31:0] entry;
  logic [15:0] left;
  logic [31:0] dest;
  logic [31:0] fallback;

  ldr_result_t due_q[$];
  int          results_seen;

  initial begin
    fail_count = 0;
    pending = 0;
    results_seen = 0;
  end

  function automatic ldr_result_t parse_rx_byte(input logic [7:0] b);
    ldr_result_t r;
    logic [15:0] w;
    r = '0;
    if (phase != PH_DONE && phase != PH_ABORT) begin
      r.echo_valid = 1'b1;
      r.echo_byte = b;
      if (!hi_next) begin
        low_hold = b;
        hi_next = 1'b1;
      end else begin
        w = {b, low_hold};
        hi_next = 1'b0;
        case (phase)
          PH_KEY: begin
            if (w == KEY_WORD) begin
              phase = PH_HEADER;
              hdr_idx = '0;
            end else begin
              entry = fallback;
              phase = PH_ABORT;
            end
          end
          PH_HEADER: begin
            if (hdr_idx < RESERVED_WORDS) begin
              hdr_idx = hdr_idx + 4'd1;
            end else if (hdr_idx == RESERVED_WORDS) begin
              hi_hold = w;
              hdr_idx = hdr_idx + 4'd1;
            end else begin
              entry = {hi_hold, w};
              phase = PH_SIZE;
            end
          end
          PH_SIZE: begin
            if (w == ZERO_WORD) begin
              phase = PH_DONE;
            end else begin
              left = w;
              phase = PH_DEST_HI;
            end
          end
          PH_DEST_HI: begin
            hi_hold = w;
            phase = PH_DEST_LO;
          end
          PH_DEST_LO: begin
            dest = {hi_hold, w};
            phase = PH_DATA;
          end
          default: begin
            r.write_valid = 1'b1;
            r.write_addr = dest;
            r.write_data = w;
            dest = dest + 32'd1;
            left = left - 16'd1;
            if (left == 16'd0) phase = PH_SIZE;
          end
        endcase
      end
    end
    case (phase)
      PH_DONE: begin
        r.status = ST_DONE;
        r.entry_addr = entry;
      end
      PH_ABORT: begin
        r.status = ST_ABORT;
        r.entry_addr = entry;
      end
      default: begin
        r.status = ST_LOADING;
        r.entry_addr = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    ldr_result_t got;
    ldr_result_t want;
    logic bad;
    if (!rst_n) begin
      phase = PH_KEY;
      low_hold = '0;
      hi_next = 1'b0;
      hdr_idx = '0;
      hi_hold = '0;
      entry = '0;
      left = '0;
      dest = '0;
      fallback = FALLBACK_RESET;
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) fallback = cfg_data;
      if (in_valid && in_ready) due_q.push_back(parse_rx_byte(in_rx_byte));
      if (out_valid && out_ready) begin
        got.echo_valid = out_echo_valid;
        got.echo_byte = out_echo_byte;
        got.write_valid = out_write_valid;
        got.write_addr = out_write_addr;
        got.write_data = out_write_data;
        got.status = out_status;
        got.entry_addr = out_entry_addr;
        results_seen++;
        if (due_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("Result %0d arrived with no byte outstanding", results_seen);
        end else begin
          want = due_q.pop_front();
          bad = (got.echo_valid !== want.echo_valid) || (got.echo_byte !== want.echo_byte) ||
                (got.write_valid !== want.write_valid) ||
                (got.write_addr !== want.write_addr) ||
                (got.write_data !== want.write_data) || (got.status !== want.status) ||
                (got.entry_addr !== want.entry_addr);
          if (bad) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("Result %0d mismatch:", results_seen);
              $display("  expected echo %0b/%02h write %0b %08h=%04h status %0d entry %08h",
                       want.echo_valid, want.echo_byte, want.write_valid, want.write_addr,
                       want.write_data, want.status, want.entry_addr);
              $display("  got      echo %0b/%02h write %0b %08h=%04h status %0d entry %08h",
                       got.echo_valid, got.echo_byte, got.write_valid, got.write_addr,
                       got.write_data, got.status, got.entry_addr);
            end
          end
        end
      end
    end
    pending = due_q.size();
  end

endmodule

FILE: dv/tb.sv
// Testbench top for the serial boot stream loader: stimulus, handshakes and verdict.
module tb;
  import slbl_pkg::*;

  localparam int HOLD_CYCLES = 60;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_rx_byte;
  logic        out_valid;
  logic        out_ready;
  logic        out_echo_valid;
  logic [7:0]  out_echo_byte;
  logic        out_write_valid;
  logic [31:0] out_write_addr;
  logic [15:0] out_write_data;
  logic [1:0]  out_status;
  logic [31:0] out_entry_addr;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  int fail_count;
  int pending;
  int bytes_sent;
  int cfg_writes;
  int blk;
  bit send_burst;
  bit drain_fast;
  bit hold_off_req;
  bit abort_run;

  serial_boot_stream_loader_top dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_echo_valid (out_echo_valid),
    .out_echo_byte  (out_echo_byte),
    .out_write_valid(out_write_valid),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_status     (out_status),
    .out_entry_addr (out_entry_addr),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  serial_boot_stream_loader_checker chk (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_rx_byte     (in_rx_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_echo_valid (out_echo_valid),
    .out_echo_byte  (out_echo_byte),
    .out_write_valid(out_write_valid),
    .out_write_addr (out_write_addr),
    .out_write_data (out_write_data),
    .out_status     (out_status),
    .out_entry_addr (out_entry_addr),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [31:0] pick_fallback();
    case ($urandom_range(0, 3))
      0: return 32'h0000_0000;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_data();
    logic [15:0] w;
    w = 16'($urandom);
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return w;
    endcase
  endfunction

  // Receiver side: random stalls, long hold-off on request.
  initial begin
    int stall;
    stall = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off_req = 1'b0;
        stall = 0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (drain_fast) begin
        out_ready <= 1'b1;
      end else begin
        stall = pick_gap();
        if (stall > 0) begin
          out_ready <= 1'b0;
          stall--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_burst ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    bytes_sent++;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_byte(w[7:0]);
    send_byte(w[15:8]);
  endtask

  // Drop valid and hold until every outstanding result has drained.
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    @(negedge clk);
  endtask

  task automatic write_fallback(input logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    cfg_writes++;
  endtask

  initial begin
    logic [15:0] bad_key;
    logic [15:0] size;
    logic [31:0] dest;
    logic [31:0] entry;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    send_burst = 1'b0;
    drain_fast = 1'b0;
    hold_off_req = 1'b0;
    bytes_sent = 0;
    cfg_writes = 0;
    blk = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_fallback(32'hFFFF_FFFF);
    write_fallback(32'h0000_0000);
    write_fallback(pick_fallback());
    abort_run = ($urandom_range(0, 7) == 0);

    if (abort_run) begin
      case ($urandom_range(0, 3))
        0: bad_key = 16'h0000;
        1: bad_key = 16'hFFFF;
        2: bad_key = KEY_WORD ^ (16'h0001 << $urandom_range(0, 15));
        default: begin
          do bad_key = 16'($urandom); while (bad_key == KEY_WORD);
        end
      endcase
      send_word(bad_key);
      settle();
      // latched entry must survive later register writes
      write_fallback(32'hFFFF_FFFF);
      write_fallback(32'h0000_0000);
      send_word(KEY_WORD);
      send_burst = 1'b1;
      hold_off_req = 1'b1;
      repeat (40) send_byte(8'($urandom));
      send_burst = 1'b0;
      while (bytes_sent < 600) send_byte(8'($urandom));
    end else begin
      send_word(KEY_WORD);
      send_word(16'h0000);
      send_word(16'hFFFF);
      repeat (6) send_word(16'($urandom));
      entry = $urandom;
      send_word(entry[31:16]);
      send_word(entry[15:0]);
      // wrap the write address
      send_word(16'd2);
      send_word(16'hFFFF);
      send_word(16'hFFFF);
      send_word(16'h0000);
      send_word(16'hFFFF);

      while (bytes_sent < 600) begin
        blk++;
        if (blk % 6 == 0) begin
          settle();
          if ($urandom_range(0, 1)) write_fallback(pick_fallback());
        end
        send_burst = (blk % 7 == 3) || (blk == 10);
        drain_fast = (blk % 7 == 3);
        if (blk == 10) hold_off_req = 1'b1;
        r = $urandom_range(0, 99);
        if (r < 80) size = 16'($urandom_range(1, 8));
        else if (r < 97) size = 16'($urandom_range(9, 40));
        else size = 16'($urandom_range(60, 120));
        if ($urandom_range(0, 4) == 0) dest = 32'hFFFF_FFFF - $urandom_range(0, 8);
        else dest = $urandom;
        send_word(size);
        send_word(dest[31:16]);
        send_word(dest[15:0]);
        repeat (size) send_word(pick_data());
      end
      send_burst = 1'b0;
      drain_fast = 1'b0;
      send_word(ZERO_WORD);
      repeat (20) send_byte(8'($urandom));
      settle();
      write_fallback(pick_fallback());
      send_word(KEY_WORD);
      repeat (10) send_byte(8'($urandom));
    end

    settle();
    repeat (4) @(posedge clk);
    $display("Sent %0d bytes in %0d random load blocks with %0d fallback register writes.",
             bytes_sent, blk, cfg_writes);
    $display("Stream ended %s.", abort_run ? "in an abort on a bad key" : "with a zero size");
    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
